>>> src/hds_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the 3D heat-diffusion stencil.
// No dependencies; the RTL uses scoped names, the tb imports it.
package hds_pkg;

	localparam int VALUE_W       = 32;
	localparam int SUM_W         = 52;
	localparam int SIZE_FIELD_W  = 7;
	localparam int LAMBDA_W      = 16;
	localparam int CFG_INDEX_W   = 3;
	localparam int CFG_DATA_W    = 16;
	localparam int DEF_MAX_SIZE  = 64;
	localparam int QUEUE_DEPTH   = 4;
	localparam int SETTLE_CYCLES = 2;

	localparam logic [SIZE_FIELD_W-1:0] SIZE_RESET   = 7'd64;
	localparam logic [LAMBDA_W-1:0]     LAMBDA_RESET = 16'd8192;
	localparam logic [SUM_W-1:0]        SUM_MAX      = {SUM_W{1'b1}};

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_SIZE_X = 3'd0,
		CFG_SIZE_Y = 3'd1,
		CFG_SIZE_Z = 3'd2,
		CFG_LAMBDA = 3'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] voxel_value;
		logic                      pad;
	} item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] new_value;
		logic                      last;
		logic [SUM_W-1:0]          change_sum;
	} result_t;

	// One queued job: centre value, six neighbours and flags.
	typedef struct packed {
		logic signed [VALUE_W-1:0] u;
		logic signed [VALUE_W-1:0] xp;
		logic signed [VALUE_W-1:0] xm;
		logic signed [VALUE_W-1:0] yp;
		logic signed [VALUE_W-1:0] ym;
		logic signed [VALUE_W-1:0] zp;
		logic signed [VALUE_W-1:0] zm;
		logic                      interior;
		logic                      last;
		logic                      first;
	} job_t;

endpackage

>>> src/hds_delay.sv
`timescale 1ns / 1ps
// Variable-length delay segment: a circular buffer memory of DEPTH words.
// Uses hds_pkg for the value width; length must be at least one.
module hds_delay #(
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int DW = $clog2(DEPTH + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              restart,
	input  logic [DW-1:0]                     len,
	input  logic signed [hds_pkg::VALUE_W-1:0] din,
	output logic signed [hds_pkg::VALUE_W-1:0] dout
);

	logic [hds_pkg::VALUE_W-1:0] mem [DEPTH];
	logic [AW-1:0]               ptr_q;
	logic [AW-1:0]               p;
	logic [DW:0]                 p_next;
	logic                        wrap;
	logic [hds_pkg::VALUE_W-1:0] dout_q;

	always_comb begin
		p      = restart ? '0 : ptr_q;
		p_next = (DW+1)'(p) + (DW+1)'(1);
		wrap   = p_next >= (DW+1)'(len);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (en) begin
			ptr_q <= wrap ? '0 : AW'(p_next);
		end
	end

	// read-first: the slot returns what was written len steps ago
	always_ff @(posedge clk) begin
		if (en) begin
			mem[p] <= din;
			dout_q <= mem[p];
		end
	end

	assign dout = $signed(dout_q);

endmodule

>>> src/hds_front.sv
`timescale 1ns / 1ps
// Front end: voxel counters, grid position and the plane delay line.
// Uses hds_pkg types and hds_delay; emits one job per result.
module hds_front #(
	parameter int MAX_SIZE = hds_pkg::DEF_MAX_SIZE,
	localparam int SW = $clog2(MAX_SIZE + 1),
	localparam int PW = 2 * SW,
	localparam int TW = 3 * SW
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  hds_pkg::item_t      item,
	input  logic [SW-1:0]       ex,
	input  logic [SW-1:0]       ey,
	input  logic [SW-1:0]       ez,
	input  logic [PW-1:0]       plane,
	input  logic [TW-1:0]       total,
	output logic                job_valid,
	output hds_pkg::job_t       job
);

	localparam int CW       = TW + 1;
	localparam int PLANE_D  = MAX_SIZE * MAX_SIZE;
	localparam int SEG_D    = PLANE_D - MAX_SIZE;
	localparam int ROW_D    = MAX_SIZE - 2;
	localparam int PLANE_LW = $clog2(PLANE_D + 1);
	localparam int SEG_LW   = $clog2(SEG_D + 1);
	localparam int ROW_LW   = $clog2(ROW_D + 1);

	logic [CW-1:0] ic_q, c, ic_d;
	logic [TW-1:0] oc_q, n, oc_d;
	logic [SW-1:0] ci_q, cj_q, ck_q, ci, cj, ck, ci_d, cj_d, ck_d;
	logic [SW:0]   k_inc, j_inc;
	logic          abandon, live, drop, adv, has_res, is_last, interior, restart;
	logic          valid_s1, interior_s1, last_s1, first_s1;

	logic [PLANE_LW-1:0] len_u;
	logic [SEG_LW-1:0]   len_1, len_4;
	logic [ROW_LW-1:0]   len_2;

	logic signed [hds_pkg::VALUE_W-1:0] u_w, yp_w, zp_w, ym_w, xm_w;
	logic signed [hds_pkg::VALUE_W-1:0] x0_q, t3_q, t4_q;

	always_comb begin
		abandon = oc_q >= total;
		c  = abandon ? '0 : ic_q;
		n  = abandon ? '0 : oc_q;
		ci = abandon ? '0 : ci_q;
		cj = abandon ? '0 : cj_q;
		ck = abandon ? '0 : ck_q;

		live    = c < CW'(total);
		drop    = live && item.pad;
		adv     = accept && !drop;
		has_res = c >= CW'(plane);
		is_last = n == total - TW'(1);
		restart = c == '0;

		interior = (ci != '0) && ((SW+1)'(ci) + (SW+1)'(1) < (SW+1)'(ex))
			&& (cj != '0) && ((SW+1)'(cj) + (SW+1)'(1) < (SW+1)'(ey))
			&& (ck != '0) && ((SW+1)'(ck) + (SW+1)'(1) < (SW+1)'(ez));

		k_inc = (SW+1)'(ck) + (SW+1)'(1);
		j_inc = (SW+1)'(cj) + (SW+1)'(1);

		ic_d = c;
		oc_d = n;
		ci_d = ci;
		cj_d = cj;
		ck_d = ck;
		if (!drop) begin
			ic_d = c + CW'(1);
			if (has_res) begin
				oc_d = n + TW'(1);
				if (k_inc == (SW+1)'(ez)) begin
					ck_d = '0;
					if (j_inc == (SW+1)'(ey)) begin
						cj_d = '0;
						ci_d = ci + SW'(1);
					end else begin
						cj_d = j_inc[SW-1:0];
					end
				end else begin
					ck_d = k_inc[SW-1:0];
				end
				// final voxel: start the next grid
				if (is_last) begin
					ic_d = '0;
					oc_d = '0;
					ci_d = '0;
					cj_d = '0;
					ck_d = '0;
				end
			end
		end
	end

	// tap distances behind the newest voxel, one step added per chained hop
	always_comb begin
		len_u = PLANE_LW'(plane);
		if ((PW+1)'(plane) > (PW+1)'(ez))
			len_1 = SEG_LW'((PW+1)'(plane) - (PW+1)'(ez));
		else
			len_1 = SEG_LW'(1);
		if ((PW+1)'(plane) > (PW+1)'(ez) + (PW+1)'(1))
			len_4 = SEG_LW'((PW+1)'(plane) - (PW+1)'(ez) - (PW+1)'(1));
		else
			len_4 = SEG_LW'(1);
		if ((SW+1)'(ez) > (SW+1)'(2))
			len_2 = ROW_LW'((SW+1)'(ez) - (SW+1)'(2));
		else
			len_2 = ROW_LW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ic_q     <= '0;
			oc_q     <= '0;
			ci_q     <= '0;
			cj_q     <= '0;
			ck_q     <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && !drop && has_res;
			if (accept) begin
				ic_q <= ic_d;
				oc_q <= oc_d;
				ci_q <= ci_d;
				cj_q <= cj_d;
				ck_q <= ck_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			interior_s1 <= interior;
			last_s1     <= is_last;
			first_s1    <= n == '0;
		end
		if (adv) begin
			x0_q <= item.voxel_value;
			t3_q <= zp_w;
			t4_q <= t3_q;
		end
	end

	hds_delay #(.DEPTH(PLANE_D)) u_centre (
		.clk(clk), .arst_n(arst_n), .en(adv), .restart(restart),
		.len(len_u), .din(item.voxel_value), .dout(u_w)
	);

	hds_delay #(.DEPTH(SEG_D)) u_seg1 (
		.clk(clk), .arst_n(arst_n), .en(adv), .restart(restart),
		.len(len_1), .din(item.voxel_value), .dout(yp_w)
	);

	hds_delay #(.DEPTH(ROW_D)) u_seg2 (
		.clk(clk), .arst_n(arst_n), .en(adv), .restart(restart),
		.len(len_2), .din(yp_w), .dout(zp_w)
	);

	hds_delay #(.DEPTH(ROW_D)) u_seg3 (
		.clk(clk), .arst_n(arst_n), .en(adv), .restart(restart),
		.len(len_2), .din(t4_q), .dout(ym_w)
	);

	hds_delay #(.DEPTH(SEG_D)) u_seg4 (
		.clk(clk), .arst_n(arst_n), .en(adv), .restart(restart),
		.len(len_4), .din(ym_w), .dout(xm_w)
	);

	always_comb begin
		job_valid    = valid_s1;
		job.u        = u_w;
		job.xp       = x0_q;
		job.xm       = xm_w;
		job.yp       = yp_w;
		job.ym       = ym_w;
		job.zp       = zp_w;
		job.zm       = t4_q;
		job.interior = interior_s1;
		job.last     = last_s1;
		job.first    = first_s1;
	end

endmodule

>>> src/hds_queue.sv
`timescale 1ns / 1ps
// Short job queue between the front end and the arithmetic back end.
// Uses hds_pkg::job_t and hds_pkg::QUEUE_DEPTH (a power of two).
module hds_queue (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     push,
	input  hds_pkg::job_t                            din,
	input  logic                                     pop,
	output hds_pkg::job_t                            dout,
	output logic [$clog2(hds_pkg::QUEUE_DEPTH+1)-1:0] count
);

	localparam int AW = $clog2(hds_pkg::QUEUE_DEPTH);
	localparam int NW = $clog2(hds_pkg::QUEUE_DEPTH + 1);

	hds_pkg::job_t mem [hds_pkg::QUEUE_DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [NW-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + AW'(1);
			if (pop)
				rd_q <= rd_q + AW'(1);
			count_q <= count_q + NW'(push) - NW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_q] <= din;
	end

	assign dout  = mem[rd_q];
	assign count = count_q;

endmodule

>>> src/hds_back.sv
`timescale 1ns / 1ps
// Back end: neighbour sum, gain multiply, rounding, clamp and change sum.
// Uses hds_pkg types; the last stage is the output register.
module hds_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         job_avail,
	input  hds_pkg::job_t                job,
	input  logic [hds_pkg::LAMBDA_W-1:0] lambda,
	output logic                         pop,
	output logic                         result_valid,
	input  logic                         result_ready,
	output hds_pkg::result_t             result
);

	localparam logic signed [38:0] VMAX = 39'sd2147483647;
	localparam logic signed [38:0] VMIN = -39'sd2147483648;

	logic en;
	logic v1_s1, v2_s2, v3_s3, v4_s4, v5_s5, v6_s6, v7_s7;

	logic signed [31:0] u_s1, u_s2, u_s3, u_s4, u_s5, u_s6;
	logic [2:0]         fl_s1, fl_s2, fl_s3, fl_s4, fl_s5, fl_s6;
	logic signed [32:0] p1_s1, p2_s1, p3_s1;
	logic signed [34:0] u6_s1;
	logic signed [33:0] q_s2;
	logic signed [35:0] r_s2;
	logic signed [36:0] s_s3;
	logic signed [53:0] prod_s4;
	logic               neg_s5, neg_s6;
	logic [52:0]        ap_s5;
	logic [36:0]        mag_s6;

	logic signed [38:0] rr;
	logic signed [31:0] nv;
	logic [52:0]        acc_sum;
	logic [51:0]        acc_base, acc_sat, acc_q;

	logic signed [31:0] nv_s7;
	logic               last_s7;
	logic [51:0]        sum_s7;

	assign en  = !v7_s7 || result_ready;
	assign pop = en && job_avail;

	// flags travel as {interior, last, first}
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			v5_s5 <= 1'b0;
			v6_s6 <= 1'b0;
			v7_s7 <= 1'b0;
			acc_q <= '0;
		end else if (en) begin
			v1_s1 <= pop;
			v2_s2 <= v1_s1;
			v3_s3 <= v2_s2;
			v4_s4 <= v3_s3;
			v5_s5 <= v4_s4;
			v6_s6 <= v5_s5;
			v7_s7 <= v6_s6;
			if (v6_s6)
				acc_q <= fl_s6[1] ? '0 : acc_sat;
		end
	end

	always_comb begin
		if (neg_s6)
			rr = 39'(u_s6) + $signed({2'b00, mag_s6});
		else
			rr = 39'(u_s6) - $signed({2'b00, mag_s6});
		if (rr > VMAX)
			nv = VMAX[31:0];
		else if (rr < VMIN)
			nv = VMIN[31:0];
		else
			nv = rr[31:0];

		// first result of a grid starts from an empty sum
		acc_base = fl_s6[0] ? '0 : acc_q;
		acc_sum  = 53'(acc_base) + 53'(mag_s6);
		acc_sat  = (acc_sum > 53'(hds_pkg::SUM_MAX)) ? hds_pkg::SUM_MAX : acc_sum[51:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1  <= job.u;
			fl_s1 <= {job.interior, job.last, job.first};
			p1_s1 <= 33'(job.xp) + 33'(job.xm);
			p2_s1 <= 33'(job.yp) + 33'(job.ym);
			p3_s1 <= 33'(job.zp) + 33'(job.zm);
			u6_s1 <= (35'(job.u) <<< 2) + (35'(job.u) <<< 1);

			u_s2  <= u_s1;
			fl_s2 <= fl_s1;
			q_s2  <= 34'(p1_s1) + 34'(p2_s1);
			r_s2  <= 36'(u6_s1) - 36'(p3_s1);

			u_s3  <= u_s2;
			fl_s3 <= fl_s2;
			s_s3  <= 37'(r_s2) - 37'(q_s2);

			u_s4    <= u_s3;
			fl_s4   <= fl_s3;
			prod_s4 <= 54'(s_s3) * 54'($signed({1'b0, lambda}));

			u_s5   <= u_s4;
			fl_s5  <= fl_s4;
			neg_s5 <= prod_s4[53];
			ap_s5  <= prod_s4[53] ? 53'(-prod_s4) : 53'(prod_s4);

			// round half away from zero; boundary voxels pass through
			u_s6   <= u_s5;
			fl_s6  <= fl_s5;
			neg_s6 <= neg_s5;
			mag_s6 <= fl_s5[2] ? 37'((ap_s5 + 53'(32768)) >> 16) : '0;

			nv_s7   <= nv;
			last_s7 <= fl_s6[1];
			sum_s7  <= fl_s6[1] ? acc_sat : '0;
		end
	end

	assign result_valid      = v7_s7;
	assign result.new_value  = nv_s7;
	assign result.last       = last_s7;
	assign result.change_sum = sum_s7;

endmodule

>>> src/heat_diffusion_stencil_3d.sv
`timescale 1ns / 1ps
// Top level of the streaming 7-point heat-diffusion stencil.
// Uses hds_pkg, hds_front, hds_queue and hds_back.
//
//  channel  | signals                              | carries
//  ---------+--------------------------------------+------------------------------
//  item     | item_valid, item_ready, item         | voxel value and pad flag
//  result   | result_valid, result_ready, result   | new value, last, change sum
//  cfg      | cfg_valid, cfg_ready, cfg_index/data | size_x, size_y, size_z, lambda
//
// One voxel word per cycle; a result, freed by the word a plane later, passes
// the front register, queue and seven-stage back end. The plane delay line is
// five read-first memories, one port pair each, advancing once per accepted
// word except dropped pads. item_ready drops after reset and each cfg write
// while the grid size products settle; the 4-entry job queue stalls the front
// end only when the result side backs up. Memories need no clearing pass.
module heat_diffusion_stencil_3d #(
	parameter int MAX_SIZE = hds_pkg::DEF_MAX_SIZE
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  hds_pkg::item_t                  item,
	output logic                            result_valid,
	input  logic                            result_ready,
	output hds_pkg::result_t                result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [hds_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [hds_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int SW = $clog2(MAX_SIZE + 1);
	localparam int PW = 2 * SW;
	localparam int TW = 3 * SW;
	localparam int NW = $clog2(hds_pkg::QUEUE_DEPTH + 1);
	localparam int STW = $clog2(hds_pkg::SETTLE_CYCLES + 1);

	logic [hds_pkg::SIZE_FIELD_W-1:0] size_x_q, size_y_q, size_z_q;
	logic [hds_pkg::LAMBDA_W-1:0]     lambda_q;
	logic [STW-1:0]                   settle_q;
	logic [SW-1:0]                    ex, ey, ez;
	logic [PW-1:0]                    plane_q;
	logic [TW-1:0]                    total_q;

	logic          accept, room, job_valid, pop;
	hds_pkg::job_t job, q_job;
	logic [NW-1:0] q_count;

	function automatic logic [SW-1:0] eff_size(input logic [hds_pkg::SIZE_FIELD_W-1:0] raw);
		logic [SW-1:0] r;
		if (raw == '0)
			r = SW'(1);
		else if (32'(raw) > 32'(MAX_SIZE))
			r = SW'(MAX_SIZE);
		else
			r = SW'(raw);
		return r;
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= hds_pkg::SIZE_RESET;
			size_y_q <= hds_pkg::SIZE_RESET;
			size_z_q <= hds_pkg::SIZE_RESET;
			lambda_q <= hds_pkg::LAMBDA_RESET;
			settle_q <= STW'(hds_pkg::SETTLE_CYCLES);
		end else if (cfg_valid) begin
			settle_q <= STW'(hds_pkg::SETTLE_CYCLES);
			case (cfg_index)
				hds_pkg::CFG_SIZE_X: size_x_q <= cfg_data[hds_pkg::SIZE_FIELD_W-1:0];
				hds_pkg::CFG_SIZE_Y: size_y_q <= cfg_data[hds_pkg::SIZE_FIELD_W-1:0];
				hds_pkg::CFG_SIZE_Z: size_z_q <= cfg_data[hds_pkg::SIZE_FIELD_W-1:0];
				hds_pkg::CFG_LAMBDA: lambda_q <= cfg_data;
				default: ;
			endcase
		end else if (settle_q != '0) begin
			settle_q <= settle_q - STW'(1);
		end
	end

	always_comb begin
		ex = eff_size(size_x_q);
		ey = eff_size(size_y_q);
		ez = eff_size(size_z_q);
	end

	// plane and grid products, registered; the grid product uses plane_q
	always_ff @(posedge clk) begin
		plane_q <= PW'(ey * ez);
		total_q <= TW'(ex * plane_q);
	end

	// a word accepted now pushes its job next cycle: keep a slot for it
	assign room       = (NW+1)'(q_count) + (NW+1)'(job_valid) < (NW+1)'(hds_pkg::QUEUE_DEPTH);
	assign item_ready = (settle_q == '0) && room;
	assign accept     = item_valid && item_ready;

	hds_front #(.MAX_SIZE(MAX_SIZE)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.ex        (ex),
		.ey        (ey),
		.ez        (ez),
		.plane     (plane_q),
		.total     (total_q),
		.job_valid (job_valid),
		.job       (job)
	);

	hds_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_valid),
		.din    (job),
		.pop    (pop),
		.dout   (q_job),
		.count  (q_count)
	);

	hds_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_avail    (q_count != '0),
		.job          (q_job),
		.lambda       (lambda_q),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of heat_diffusion_stencil_3d: streams whole grids
// with random values, gaps and stalls, and checks each result against a model.
// Depends on hds_pkg and the RTL under src/.
module tb;
	import hds_pkg::*;

	localparam int WIN_DEPTH = 2 * DEF_MAX_SIZE * DEF_MAX_SIZE + 1;
	localparam int WD_LIMIT  = 20000;
	localparam int DRAIN     = 30;
	localparam int HOLD_LEN  = 300;

	class stencil_scoreboard;
		logic [VALUE_W-1:0] window[WIN_DEPTH];
		int unsigned voxels_in, voxels_out;
		longint unsigned change_acc;
		int unsigned size_x, size_y, size_z, gain;
		result_t pending[$];
		int errors;

		function new();
			size_x = 64;
			size_y = 64;
			size_z = 64;
			gain   = 8192;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
			case (idx)
				CFG_SIZE_X: size_x = 32'(d[SIZE_FIELD_W-1:0]);
				CFG_SIZE_Y: size_y = 32'(d[SIZE_FIELD_W-1:0]);
				CFG_SIZE_Z: size_z = 32'(d[SIZE_FIELD_W-1:0]);
				CFG_LAMBDA: gain = 32'(d);
				default: ;
			endcase
		endfunction

		function int unsigned clamp_size(int unsigned v);
			if (v < 1) return 1;
			if (v > DEF_MAX_SIZE) return DEF_MAX_SIZE;
			return v;
		endfunction

		function longint neighbor(int unsigned pos);
			logic signed [VALUE_W-1:0] w;
			w = window[pos % WIN_DEPTH];
			return longint'(w);
		endfunction

		function void clear_sweep();
			voxels_in  = 0;
			voxels_out = 0;
			change_acc = 0;
		endfunction

		// Note an accepted word and queue the result it releases, if any.
		function void note_item(item_t it);
			int unsigned sx, sy, sz, plane, total, c, n, i, j, k, back;
			longint u, r, s, p, du;
			longint unsigned mag, ap;
			result_t res;
			sx = clamp_size(size_x);
			sy = clamp_size(size_y);
			sz = clamp_size(size_z);
			plane = sy * sz;
			total = sx * plane;
			mag = 0;
			if (voxels_out >= total) clear_sweep();
			c = voxels_in;
			if (c < total) begin
				if (it.pad) return;
				window[c % WIN_DEPTH] = it.voxel_value;
			end
			voxels_in++;
			if (c < plane) return;
			n = voxels_out;
			i = n / plane;
			j = (n / sz) % sy;
			k = n % sz;
			back = (n % WIN_DEPTH) + WIN_DEPTH;
			u = neighbor(n);
			r = u;
			if (i >= 1 && i + 1 < sx && j >= 1 && j + 1 < sy && k >= 1 && k + 1 < sz) begin
				s = 6 * u - neighbor(n + plane) - neighbor(back - plane)
					- neighbor(n + sz) - neighbor(back - sz)
					- neighbor(n + 1) - neighbor(back - 1);
				p = s * longint'(gain);
				ap = (p < 0) ? -p : p;
				mag = (ap + 32768) >> 16;
				du = (p < 0) ? -longint'(mag) : longint'(mag);
				r = u - du;
				if (r > 64'sh7fffffff) r = 64'sh7fffffff;
				if (r < -64'sh80000000) r = -64'sh80000000;
			end
			change_acc += mag;
			if (change_acc > SUM_MAX) change_acc = SUM_MAX;
			voxels_out++;
			res.new_value  = r[VALUE_W-1:0];
			res.last       = (n == total - 1);
			res.change_sum = res.last ? change_acc[SUM_W-1:0] : '0;
			pending.push_back(res);
			if (res.last) clear_sweep();
		endfunction

		function void check(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				$error("result with nothing expected: %h", got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.new_value !== want.new_value) begin
				$error("new_value expected %h got %h", want.new_value, got.new_value);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last expected %b got %b", want.last, got.last);
				errors++;
			end
			if (got.change_sum !== want.change_sum) begin
				$error("change_sum expected %h got %h", want.change_sum, got.change_sum);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic item_valid = 0;
	logic item_ready;
	item_t item = '0;
	logic result_valid;
	logic result_ready = 0;
	result_t result;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	stencil_scoreboard sb = new();
	int send_idle = 27;
	int recv_idle = 75;
	int words_sent = 0;
	bit hold_req = 0;
	bit hold_done = 0;
	int hold_cnt = 0;
	int stall_cnt = 0;

	heat_diffusion_stencil_3d u_dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// Result side: random stalls plus one long hold-off to back the block up.
	always @(posedge clk) begin
		if (result_valid && result_ready) sb.check(result);
		if (hold_cnt > 0) begin
			result_ready <= 1'b0;
			hold_cnt <= hold_cnt - 1;
		end else if (hold_req && !hold_done) begin
			result_ready <= 1'b0;
			hold_cnt <= HOLD_LEN;
			hold_done <= 1'b1;
		end else begin
			result_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready)
				|| (cfg_valid && cfg_ready))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= WD_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic send_word(logic signed [VALUE_W-1:0] v, logic pad);
		item_t it;
		it.voxel_value = v;
		it.pad = pad;
		while ($urandom_range(99) < send_idle) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		sb.note_item(it);
		words_sent++;
		if (words_sent == 200) hold_req = 1;
		if (words_sent == 470) begin
			send_idle = 75;
			recv_idle = 27;
		end
		if (words_sent == 940) begin
			send_idle = 0;
			recv_idle = 0;
		end
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(idx, d);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [VALUE_W-1:0] rand_value();
		int pick;
		pick = $urandom_range(9);
		if (pick < 6) return $urandom;
		if (pick < 8) return $urandom_range(32'h0003ffff) - 32'h00020000;
		case ($urandom_range(3))
			0: return 32'h80000000;
			1: return 32'h7fffffff;
			2: return 32'h0;
			default: return 32'hffffffff;
		endcase
	endfunction

	// One whole sweep: registers, voxels with stray early pads, then the flush.
	task automatic run_grid(int nx, int ny, int nz, int lam);
		int plane, total;
		write_reg(CFG_SIZE_X, CFG_DATA_W'(nx));
		write_reg(CFG_SIZE_Y, CFG_DATA_W'(ny));
		write_reg(CFG_SIZE_Z, CFG_DATA_W'(nz));
		write_reg(CFG_LAMBDA, CFG_DATA_W'(lam));
		plane = sb.clamp_size(ny) * sb.clamp_size(nz);
		total = sb.clamp_size(nx) * plane;
		for (int c = 0; c < total; c++) begin
			if ($urandom_range(9) == 0) send_word(rand_value(), 1'b1);
			send_word(rand_value(), 1'b0);
		end
		for (int c = 0; c < plane; c++)
			send_word(rand_value(), 1'($urandom_range(1)));
		drain();
	endtask

	function automatic int rand_dim();
		int pick;
		pick = $urandom_range(19);
		if (pick == 0) return 0;
		if (pick == 1) return $urandom_range(127, 65);
		return $urandom_range(6, 1);
	endfunction

	initial begin
		int nx, ny, nz;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero size acts as one: early pad dropped, late voxel flushes.
		write_reg(CFG_SIZE_X, 16'd0);
		write_reg(CFG_SIZE_Y, 16'd1);
		write_reg(CFG_SIZE_Z, 16'd1);
		write_reg(CFG_LAMBDA, 16'hffff);
		send_word(32'h0, 1'b1);
		send_word(32'h80000000, 1'b0);
		send_word(32'h12345678, 1'b0);
		drain();

		// Hot centre in a cold cube at full gain: saturate low.
		write_reg(CFG_SIZE_X, 16'd3);
		write_reg(CFG_SIZE_Y, 16'd3);
		write_reg(CFG_SIZE_Z, 16'd3);
		for (int c = 0; c < 27; c++)
			send_word((c == 13) ? 32'h7fffffff : 32'h80000000, 1'b0);
		for (int c = 0; c < 9; c++) send_word(32'h0, 1'b1);
		drain();

		run_grid(3, 3, 3, 0);
		run_grid(64, 1, 1, 65535);
		run_grid(1, 127, 1, 1);

		while (words_sent < 1400) begin
			nx = rand_dim();
			ny = rand_dim();
			nz = rand_dim();
			if (sb.clamp_size(nx) * sb.clamp_size(ny) * sb.clamp_size(nz) > 260) begin
				ny = 1;
				nz = $urandom_range(4, 3);
			end
			run_grid(nx, ny, nz, $urandom_range(3) == 0 ? $urandom_range(65535)
				: $urandom_range(16384));
		end

		if (sb.pending.size() != 0) begin
			$error("%0d results never arrived", sb.pending.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
